// ----- rtl/lprl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lprl_pkg;

  localparam int ROUTE_ENTRIES_DEFAULT = 16;

  localparam logic       OP_WRITE  = 1'b0;
  localparam logic       OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_WRITE_DONE = 2'd0;
  localparam logic [1:0] ST_HIT        = 2'd1;
  localparam logic [1:0] ST_MISS       = 2'd2;
  localparam logic [1:0] ST_BAD_PREFIX = 2'd3;

  localparam logic [5:0]  MAX_PREFIX = 6'd32;
  localparam logic [31:0] FULL_MASK  = 32'hffffffff;

  typedef struct packed {
    logic        valid;
    logic [31:0] network;
    logic [5:0]  prefix;
    logic [15:0] metric;
  } route_t;

  typedef struct packed {
    logic cnt_rst;
    logic cnt_inc;
    logic clr_we;
    logic accept;
    logic rd_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
  } sts_t;

  function automatic logic [31:0] mask_of(input logic [5:0] plen);
    logic [31:0] m;
    if (plen == 6'd0) begin
      m = 32'd0;
    end else begin
      m = FULL_MASK << (MAX_PREFIX - plen);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lprl_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lprl_datapath #(
  parameter int ROUTE_ENTRIES = lprl_pkg::ROUTE_ENTRIES_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lprl_pkg::cmd_t cmd,
  output lprl_pkg::sts_t     sts,
  input  wire logic          op,
  input  wire logic [3:0]    entry_index,
  input  wire logic          entry_valid,
  input  wire logic [31:0]   entry_network,
  input  wire logic [5:0]    entry_prefix_len,
  input  wire logic [15:0]   entry_metric,
  input  wire logic [31:0]   dest_address,
  output logic [1:0]         status,
  output logic [3:0]         match_index,
  output logic [5:0]         match_prefix_len,
  output logic [15:0]        match_metric
);
  import lprl_pkg::*;

  localparam int AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CW = (AW + 1 > 4) ? AW + 1 : 4;
  localparam logic [AW-1:0] LAST = AW'(ROUTE_ENTRIES - 1);

  route_t        mem [ROUTE_ENTRIES];
  route_t        rd_data;
  logic [AW-1:0] rd_idx;
  logic          rd_vld;
  logic [AW-1:0] cnt;

  logic          req_lookup;
  logic          req_bad;
  logic [31:0]   dest;

  logic          found;
  logic [AW-1:0] best_idx;
  logic [5:0]    best_plen;
  logic [15:0]   best_metric;

  logic          wr_ok;
  logic          bad;
  logic [31:0]   mask;
  logic          take;

  assign sts.cnt_last = (cnt == LAST);

  assign bad   = (entry_prefix_len > MAX_PREFIX);
  assign wr_ok = cmd.accept && (op == OP_WRITE) && !bad &&
                 (CW'(entry_index) < CW'(ROUTE_ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_rst) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      mem[cnt] <= '0;
    end else if (wr_ok) begin
      mem[AW'(entry_index)] <= '{valid: entry_valid, network: entry_network,
                                 prefix: entry_prefix_len, metric: entry_metric};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cnt];
      rd_idx  <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
    end
  end

  assign mask = mask_of(rd_data.prefix);
  assign take = rd_vld && rd_data.valid &&
                ((dest & mask) == (rd_data.network & mask)) &&
                (!found || (rd_data.prefix > best_plen) ||
                 ((rd_data.prefix == best_plen) && (rd_data.metric < best_metric)));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_lookup <= (op == OP_LOOKUP);
      req_bad    <= bad;
      dest       <= dest_address;
      found      <= 1'b0;
    end else if (take) begin
      found       <= 1'b1;
      best_idx    <= rd_idx;
      best_plen   <= rd_data.prefix;
      best_metric <= rd_data.metric;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      match_index      <= 4'd0;
      match_prefix_len <= 6'd0;
      match_metric     <= 16'd0;
      if (!req_lookup) begin
        status <= req_bad ? ST_BAD_PREFIX : ST_WRITE_DONE;
      end else if (found) begin
        status           <= ST_HIT;
        match_index      <= 4'(best_idx);
        match_prefix_len <= best_plen;
        match_metric     <= best_metric;
      end else begin
        status <= ST_MISS;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lprl_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lprl_controller (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           op,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lprl_pkg::cmd_t      cmd,
  input  wire lprl_pkg::sts_t sts
);
  import lprl_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_CLEAR: begin
        cmd.clr_we  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_rst = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept  = 1'b1;
          cmd.cnt_rst = 1'b1;
          state_next  = (op == OP_LOOKUP) ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_rst = 1'b1;
          state_next  = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/longest_prefix_route_lookup_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Route table with longest-prefix match over ROUTE_ENTRIES slots held in a
// single-port memory. After reset the block clears the table slot by slot
// and holds in_stall high meanwhile. A lookup request reads one slot per
// cycle from the memory; in_stall stays high until a request's result is
// loaded, so no new request is taken before the last one is through.
// One result is returned per request, in order.

module longest_prefix_route_lookup_unit #(
  parameter int ROUTE_ENTRIES = lprl_pkg::ROUTE_ENTRIES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [3:0]  entry_index,
  input  wire logic        entry_valid,
  input  wire logic [31:0] entry_network,
  input  wire logic [5:0]  entry_prefix_len,
  input  wire logic [15:0] entry_metric,
  input  wire logic [31:0] dest_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [3:0]       match_index,
  output logic [5:0]       match_prefix_len,
  output logic [15:0]      match_metric
);
  import lprl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lprl_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  lprl_datapath #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .op               (op),
    .entry_index      (entry_index),
    .entry_valid      (entry_valid),
    .entry_network    (entry_network),
    .entry_prefix_len (entry_prefix_len),
    .entry_metric     (entry_metric),
    .dest_address     (dest_address),
    .status           (status),
    .match_index      (match_index),
    .match_prefix_len (match_prefix_len),
    .match_metric     (match_metric)
  );

endmodule

`default_nettype wire

// ----- rtl/lprl_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lprl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [3:0]  match_index,
  input wire logic [5:0]  match_prefix_len,
  input wire logic [15:0] match_metric
);
  import lprl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(match_index))
    else $error("stalled result changed");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> in_stall)
    else $error("request taken while the table is being cleared");

  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_HIT) |->
      (match_index == 4'd0) && (match_prefix_len == 6'd0) && (match_metric == 16'd0))
    else $error("nonzero match fields without a hit");

  a_hit_prefix: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_HIT) |-> (match_prefix_len <= MAX_PREFIX))
    else $error("hit reports an illegal prefix length");

endmodule

bind longest_prefix_route_lookup_unit lprl_checker u_chk (.*);

`default_nettype wire
